// ===== src/pxu_pkg.sv =====
// Package for the pixel unpacker: source format codes and float helper functions.
// No dependencies.
package pxu_pkg;

   localparam int FmtWidth = 3;

   typedef enum logic [FmtWidth-1:0] {
      FMT_GREY8  = 3'd0,
      FMT_RG8    = 3'd1,
      FMT_RGB8   = 3'd2,
      FMT_BGR8   = 3'd3,
      FMT_RGBA8  = 3'd4,
      FMT_BGRA8  = 3'd5,
      FMT_HALF   = 3'd6,
      FMT_SINGLE = 3'd7
   } fmt_type;

   localparam fmt_type FmtReset = FMT_RGBA8;

   // Half to single bit pattern. Half subnormals lie below 2^-14 and always
   // give 0 after scaling, so they are mapped to a signed zero.
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic       sgn;
      logic [4:0] ex;
      logic [9:0] man;
      logic [7:0] sex;
      sgn = h[15];
      ex  = h[14:10];
      man = h[9:0];
      if (ex == 5'd0) begin
         return {sgn, 31'd0};
      end
      if (ex == 5'h1F) begin
         sex = 8'hFF;
      end else begin
         sex = {3'd0, ex} + 8'd112;
      end
      return {sgn, sex, man, 13'd0};
   endfunction

endpackage

// ===== src/pixel_unpack_to_rgba8.sv =====
// Top level of the pixel unpacker: input register, format decode, result register.
// Depends on pxu_pkg and pxu_f2u8.
//
//   channel   ports                                   direction
//   req       req_valid/req_stall, pixel, last_in     in
//   rsp       rsp_valid/rsp_stall, r g b a, last_out  out
//   csr       csr_write_enable, csr_write_data        in
//
// An accepted beat passes the input register and then the result register;
// one beat per cycle is sustained while the result is not stalled. The float
// scaling path sits between them. Reset empties both stages and sets the
// format to RGBA8. A stalled result holds; an empty input register takes one
// more beat while the result waits, after that the input stalls.
module pixel_unpack_to_rgba8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_pixel_low,
   input  logic [63:0] req_pixel_high,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_out,
   input  logic        csr_write_enable,
   input  logic [pxu_pkg::FmtWidth-1:0] csr_write_data
);
   import pxu_pkg::*;

   fmt_type     fmt_ff;
   logic        s1_valid_ff;
   logic [63:0] lo_ff;
   logic [63:0] hi_ff;
   logic        last_ff;
   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic        last_out_ff;
   logic        adv2;
   logic        adv1;
   logic [7:0]  red_in, green_in, blue_in, alpha_in;
   logic [31:0] fin [4];
   logic [7:0]  fout [4];

   // handshake
   assign adv2      = !rsp_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   // format register
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FmtReset;
      end else if (csr_write_enable) begin
         fmt_ff <= fmt_type'(csr_write_data);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         lo_ff   <= req_pixel_low;
         hi_ff   <= req_pixel_high;
         last_ff <= req_last_in;
      end
   end

   // float channel inputs
   always_comb begin
      if (fmt_ff == FMT_HALF) begin
         fin[0] = half_to_single(lo_ff[15:0]);
         fin[1] = half_to_single(lo_ff[31:16]);
         fin[2] = half_to_single(lo_ff[47:32]);
         fin[3] = half_to_single(lo_ff[63:48]);
      end else begin
         fin[0] = lo_ff[31:0];
         fin[1] = lo_ff[63:32];
         fin[2] = hi_ff[31:0];
         fin[3] = hi_ff[63:32];
      end
   end

   for (genvar c = 0; c < 4; c++) begin : g_chan
      pxu_f2u8 u_conv (
         .value (fin[c]),
         .level (fout[c])
      );
   end

   // format decode
   always_comb begin
      unique case (fmt_ff)
         FMT_GREY8: begin
            red_in = lo_ff[7:0]; green_in = lo_ff[7:0];
            blue_in = lo_ff[7:0]; alpha_in = 8'hFF;
         end
         FMT_RG8: begin
            red_in = lo_ff[7:0]; green_in = lo_ff[15:8];
            blue_in = 8'd0; alpha_in = 8'hFF;
         end
         FMT_RGB8: begin
            red_in = lo_ff[7:0]; green_in = lo_ff[15:8];
            blue_in = lo_ff[23:16]; alpha_in = 8'hFF;
         end
         FMT_BGR8: begin
            red_in = lo_ff[23:16]; green_in = lo_ff[15:8];
            blue_in = lo_ff[7:0]; alpha_in = 8'hFF;
         end
         FMT_RGBA8: begin
            red_in = lo_ff[7:0]; green_in = lo_ff[15:8];
            blue_in = lo_ff[23:16]; alpha_in = lo_ff[31:24];
         end
         FMT_BGRA8: begin
            red_in = lo_ff[23:16]; green_in = lo_ff[15:8];
            blue_in = lo_ff[7:0]; alpha_in = lo_ff[31:24];
         end
         default: begin
            red_in = fout[0]; green_in = fout[1];
            blue_in = fout[2]; alpha_in = fout[3];
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         alpha_ff    <= alpha_in;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_red      = red_ff;
   assign rsp_green    = green_ff;
   assign rsp_blue     = blue_ff;
   assign rsp_alpha    = alpha_ff;
   assign rsp_last_out = last_out_ff;

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");
   a_rise_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item");
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv2) |=> rsp_valid_ff)
      else $error("item lost between stages");
`endif

endmodule

// ===== src/pxu_f2u8.sv =====
// Float channel to 8-bit unsigned: clamp to [0,1], scale by 255 in single
// precision, round half away from zero. Depends on pxu_pkg.
module pxu_f2u8 (
   input  logic [31:0] value,
   output logic [7:0]  level
);
   import pxu_pkg::*;

   logic        sgn;
   logic [7:0]  ex;
   logic [22:0] frac;
   logic [23:0] mant;
   logic [31:0] prod;
   logic [32:0] kept;
   logic [32:0] rnd;
   logic        guard;
   logic        sticky;
   logic        lsb;
   logic [3:0]  shamt;
   logic [33:0] sum;
   logic [33:0] half_bias;
   logic [33:0] scaled;

   always_comb begin
      sgn   = value[31];
      ex    = value[30:23];
      frac  = value[22:0];
      mant  = {1'b1, frac};
      // mant * 255 as a shift and subtract
      prod  = {mant, 8'd0} - {8'd0, mant};
      // round the product to 24 significant bits, ties to even
      if (prod[31]) begin
         kept   = {1'b0, prod[31:8], 8'd0};
         guard  = prod[7];
         sticky = |prod[6:0];
         lsb    = prod[8];
         rnd    = kept + ((guard && (sticky || lsb)) ? 33'h100 : 33'h0);
      end else begin
         kept   = {1'b0, prod[31:7], 7'd0};
         guard  = prod[6];
         sticky = |prod[5:0];
         lsb    = prod[7];
         rnd    = kept + ((guard && (sticky || lsb)) ? 33'h80 : 33'h0);
      end
      // exponent offset below 1.0; only 0..9 can reach a nonzero level
      shamt     = 4'(8'd127 - ex);
      half_bias = 34'd1 << (6'd22 + {2'd0, shamt});
      sum       = {1'b0, rnd} + half_bias;
      scaled    = sum >> (6'd23 + {2'd0, shamt});

      if (ex == 8'hFF && frac != 23'd0) begin
         level = 8'd0;
      end else if (sgn || ex == 8'd0) begin
         level = 8'd0;
      end else if (ex > 8'd127 || (ex == 8'd127 && frac != 23'd0)) begin
         level = 8'hFF;
      end else if (ex < 8'd117) begin
         level = 8'd0;
      end else begin
         level = scaled[7:0];
      end
   end

endmodule

// ===== verif/pixel_unpack_to_rgba8_tb.sv =====
// Testbench for pixel_unpack_to_rgba8: directed table and random pixels over all formats, every result
// checked against the table's expected value or an in-bench decoder. Depends on pxu_pkg and the RTL.
`timescale 1ns / 1ps
module pixel_unpack_to_rgba8_tb;
   import pxu_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } rgba_beat_type;

   typedef struct packed {
      fmt_type       fmt;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic          last;
      logic          typed;
      rgba_beat_type want;
   } steer_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_pixel_low;
   logic [63:0] req_pixel_high;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_last_out;
   logic        csr_write_enable;
   logic [FmtWidth-1:0] csr_write_data;

   // typed expectation travels with the beat it belongs to
   logic          beat_typed;
   rgba_beat_type beat_want;

   rgba_beat_type pending_rgba[$];
   fmt_type       fmt_now = FmtReset;
   bit            quiet_tail = 1'b0;
   int            fails = 0;
   int            cycle_count = 0;
   int            pixels_sent = 0;
   int            pixels_checked = 0;
   int            directed_count = 0;
   steer_row_type steer_rows[17];

   pixel_unpack_to_rgba8 uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_low(req_pixel_low), .req_pixel_high(req_pixel_high),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_alpha(rsp_alpha), .rsp_last_out(rsp_last_out),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // half bit pattern to single bit pattern, subnormals normalized exactly
   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [10:0] man;
      int          shifts;
      man = {1'b0, h[9:0]};
      shifts = 0;
      if (h[14:10] == 5'd0) begin
         if (man == 11'd0) return {h[15], 31'd0};
         while (man[10] == 1'b0) begin
            man = man << 1;
            shifts++;
         end
         return {h[15], 8'(113 - shifts), man[9:0], 13'd0};
      end
      if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
   endfunction

   // clamp to [0,1], times 255 rounded to single, then round half away from zero
   function automatic logic [7:0] scale_unit_to_byte(input logic [31:0] f);
      longint unsigned m, prod, q, rem, halfb, t, fr;
      int ee, len, s, sh;
      if (f[30:23] == 8'hFF) return (f[22:0] != 0 || f[31]) ? 8'd0 : 8'd255;
      if (f[31] || f[30:0] == 31'd0) return 8'd0;
      if (f[30:23] >= 8'd127) return 8'd255;
      m = (f[30:23] == 8'd0) ? longint'(f[22:0]) : longint'({1'b1, f[22:0]});
      ee = (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
      prod = m * 255;
      len = 0;
      while ((prod >> len) != 0) len++;
      s = (len > 24) ? len - 24 : 0;
      q = prod >> s;
      if (s > 0) begin
         rem = prod & ((64'd1 << s) - 1);
         halfb = 64'd1 << (s - 1);
         if (rem > halfb || (rem == halfb && q[0])) q++;
      end
      sh = 150 - s - ee;
      if (sh >= 62) return 8'd0;
      t = q >> sh;
      fr = q & ((64'd1 << sh) - 1);
      if (fr >= (64'd1 << (sh - 1))) t++;
      return t[7:0];
   endfunction

   function automatic rgba_beat_type decode_pixel(input fmt_type fmt, input logic [63:0] lo,
                                                  input logic [63:0] hi, input logic last);
      rgba_beat_type b;
      b.last = last;
      b.alpha = 8'hFF;
      case (fmt)
         FMT_GREY8: begin
            b.red = lo[7:0]; b.green = lo[7:0]; b.blue = lo[7:0];
         end
         FMT_RG8: begin
            b.red = lo[7:0]; b.green = lo[15:8]; b.blue = 8'd0;
         end
         FMT_RGB8, FMT_RGBA8: begin
            b.red = lo[7:0]; b.green = lo[15:8]; b.blue = lo[23:16];
            if (fmt == FMT_RGBA8) b.alpha = lo[31:24];
         end
         FMT_BGR8, FMT_BGRA8: begin
            b.red = lo[23:16]; b.green = lo[15:8]; b.blue = lo[7:0];
            if (fmt == FMT_BGRA8) b.alpha = lo[31:24];
         end
         FMT_HALF: begin
            b.red   = scale_unit_to_byte(widen_half(lo[15:0]));
            b.green = scale_unit_to_byte(widen_half(lo[31:16]));
            b.blue  = scale_unit_to_byte(widen_half(lo[47:32]));
            b.alpha = scale_unit_to_byte(widen_half(lo[63:48]));
         end
         default: begin
            b.red   = scale_unit_to_byte(lo[31:0]);
            b.green = scale_unit_to_byte(lo[63:32]);
            b.blue  = scale_unit_to_byte(hi[31:0]);
            b.alpha = scale_unit_to_byte(hi[63:32]);
         end
      endcase
      return b;
   endfunction

   // mostly values in [0,2), with specials and raw noise mixed in
   function automatic logic [15:0] rand_half();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return {1'b0, 5'($urandom_range(0, 15)), 10'($urandom)};
         6: return 16'h3C00;
         7: return {1'b0, 5'h1F, 10'($urandom)};
         8: return {1'b1, 15'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_single();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return {1'b0, 8'($urandom_range(100, 127)), 23'($urandom)};
         6: return 32'h3F80_0000;
         7: return {1'b0, 8'hFF, 23'($urandom_range(0, 3))};
         8: return {1'b1, 31'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // monitor: predict on accepted input beats, compare on accepted result beats
   always @(posedge clock) begin
      rgba_beat_type exp_b;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_write_enable) fmt_now = fmt_type'(csr_write_data);
         if (req_valid && !req_stall)
            pending_rgba.push_back(beat_typed ? beat_want :
               decode_pixel(fmt_now, req_pixel_low, req_pixel_high, req_last_in));
         if (rsp_valid && !rsp_stall) begin
            if (pending_rgba.size() == 0) begin
               $error("result beat with nothing expected");
               fails++;
            end else begin
               exp_b = pending_rgba.pop_front();
               pixels_checked++;
               if (rsp_red !== exp_b.red) begin
                  $error("red expected %0h got %0h", exp_b.red, rsp_red); fails++;
               end
               if (rsp_green !== exp_b.green) begin
                  $error("green expected %0h got %0h", exp_b.green, rsp_green); fails++;
               end
               if (rsp_blue !== exp_b.blue) begin
                  $error("blue expected %0h got %0h", exp_b.blue, rsp_blue); fails++;
               end
               if (rsp_alpha !== exp_b.alpha) begin
                  $error("alpha expected %0h got %0h", exp_b.alpha, rsp_alpha); fails++;
               end
               if (rsp_last_out !== exp_b.last) begin
                  $error("last_out expected %0h got %0h", exp_b.last, rsp_last_out); fails++;
               end
            end
         end
      end
   end

   // result side stall: random bursts between free stretches
   initial begin
      forever begin
         if (quiet_tail) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12))
               @(posedge clock);
            if (!quiet_tail) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 13)) @(posedge clock);
            end
         end
      end
   end

   task automatic send_pixel(input logic [63:0] lo, input logic [63:0] hi, input logic last,
                             input logic typed, input rgba_beat_type want);
      req_valid <= 1'b1;
      req_pixel_low <= lo;
      req_pixel_high <= hi;
      req_last_in <= last;
      beat_typed <= typed;
      beat_want <= want;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // wait for every outstanding result, then let the pipeline empty
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rgba.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_format(input fmt_type fmt);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= fmt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // driver
   initial begin
      fmt_type     fmt;
      logic [63:0] lo, hi;
      int          per_phase;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_pixel_low <= '0;
      req_pixel_high <= '0;
      req_last_in <= 1'b0;
      beat_typed <= 1'b0;
      beat_want <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= FmtReset;

      steer_rows = '{
         // first row runs at the reset format
         '{FMT_RGBA8, 64'h0000_0000_4433_2211, 64'h0, 1'b0, 1'b1, '{8'h11, 8'h22, 8'h33, 8'h44, 1'b0}},
         '{FMT_RGBA8, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
           '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
         '{FMT_GREY8, 64'hFFFF_FFFF_FFFF_FF80, 64'h0, 1'b0, 1'b1, '{8'h80, 8'h80, 8'h80, 8'hFF, 1'b0}},
         '{FMT_GREY8, 64'h0, 64'h0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1}},
         '{FMT_RG8, 64'hFFFF_FFFF_FFFF_3412, 64'h0, 1'b0, 1'b1, '{8'h12, 8'h34, 8'h00, 8'hFF, 1'b0}},
         '{FMT_RGB8, 64'h0000_0000_0056_3412, 64'h0, 1'b0, 1'b1, '{8'h12, 8'h34, 8'h56, 8'hFF, 1'b0}},
         '{FMT_BGR8, 64'h0000_0000_0056_3412, 64'h0, 1'b0, 1'b1, '{8'h56, 8'h34, 8'h12, 8'hFF, 1'b0}},
         '{FMT_BGRA8, 64'h0000_0000_7856_3412, 64'h0, 1'b1, 1'b1, '{8'h56, 8'h34, 8'h12, 8'h78, 1'b1}},
         '{FMT_HALF, 64'h3C00_3C00_3C00_3C00, 64'h0, 1'b0, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
         // signed zeros
         '{FMT_HALF, 64'h8000_0000_8000_0000, 64'h0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
         // NaN of both signs, +inf, -inf
         '{FMT_HALF, 64'hFC00_7C00_FE00_7E00, 64'h0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
         // one half, above one, subnormal, negative
         '{FMT_HALF, 64'hBC00_0001_4000_3800, 64'h0, 1'b0, 1'b1, '{8'h80, 8'hFF, 8'h00, 8'h00, 1'b0}},
         '{FMT_HALF, 64'h3555_2E66_03FF_3BFF, 64'h0, 1'b1, 1'b0, '0},
         '{FMT_SINGLE, 64'h3F00_0000_3F80_0000, 64'h7F80_0000_7FC0_0000, 1'b0, 1'b1,
           '{8'hFF, 8'h80, 8'h00, 8'hFF, 1'b0}},
         // negative, smallest subnormal, largest finite, negative zero
         '{FMT_SINGLE, 64'h0000_0001_BF80_0000, 64'h8000_0000_7F7F_FFFF, 1'b0, 1'b1,
           '{8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
         '{FMT_SINGLE, 64'h3B80_8081_3E4C_CCCD, 64'h3F7F_FFFF_3EFF_FFFF, 1'b0, 1'b0, '0},
         '{FMT_SINGLE, 64'h3F00_8081_3A80_0000, 64'hFFC0_0001_3C00_0000, 1'b1, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (steer_rows[i]) begin
         if (steer_rows[i].fmt != fmt_now) load_format(steer_rows[i].fmt);
         send_pixel(steer_rows[i].lo, steer_rows[i].hi, steer_rows[i].last, 1'b1 & steer_rows[i].typed,
                    steer_rows[i].want);
         directed_count++;
      end

      // random phases, each at one format; extremes forced at the ends
      for (int phase = 0; phase < 18; phase++) begin
         if (phase == 0) fmt = FMT_GREY8;
         else if (phase == 1 || phase == 17) fmt = FMT_SINGLE;
         else fmt = fmt_type'($urandom_range(0, 7));
         load_format(fmt);
         if (phase >= 16) quiet_tail = 1'b1;
         per_phase = 105;
         for (int n = 0; n < per_phase; n++) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) begin
               if (fmt == FMT_HALF)
                  lo = {rand_half(), rand_half(), rand_half(), rand_half()};
               else if (fmt == FMT_SINGLE) begin
                  lo = {rand_single(), rand_single()};
                  hi = {rand_single(), rand_single()};
               end
            end
            if (phase == 8 && n == 50) drain_results();
            send_pixel(lo, hi, 1'($urandom_range(0, 15) == 0), 1'b0, '0);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (pending_rgba.size() != 0) begin
         $error("%0d results never arrived", pending_rgba.size());
         fails++;
      end
      $display("Sent %0d pixels (%0d from the directed table) across all source formats,",
               pixels_sent, directed_count);
      $display("compared %0d result beats with random idling on both sides.", pixels_checked);
      if (fails == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
